// ===== hw/rtl/servo_frame_to_thrust_with_failsafe_assert.svh =====
// Assertion macros shared by the block's modules.
`ifndef SERVO_FRAME_TO_THRUST_WITH_FAILSAFE_ASSERT_SVH
`define SERVO_FRAME_TO_THRUST_WITH_FAILSAFE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfth_pkg.sv =====
package sfth_pkg;

  // Channel capture limit
  localparam int unsigned MaxChannels = 32;

  // Frame format
  localparam logic [15:0] MagicShort    = 16'd18458;
  localparam logic [15:0] MagicLong     = 16'd29569;
  localparam logic [15:0] PulseMin      = 16'd800;
  localparam logic [15:0] PulseMax      = 16'd2200;
  localparam logic [5:0]  MinFrameWords = 6'd20;
  localparam logic [5:0]  HeaderWords   = 6'd4;
  localparam logic [5:0]  PosMax        = 6'd63;

  // Divider: quotient never exceeds 16 bits since offset <= span
  localparam int unsigned DivSteps = 16;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // Register reset values
  localparam logic [11:0] TrimRst   = 12'd1500;
  localparam logic [10:0] SpanRst   = 11'd400;
  localparam logic [10:0] DeadRst   = 11'd20;
  localparam logic [15:0] FullRst   = 16'd6000;
  localparam logic [4:0]  LeftRst   = 5'd0;
  localparam logic [4:0]  RightRst  = 5'd2;
  localparam logic [15:0] SilentRst = 16'd1000;

  // Register indexes
  typedef enum logic [2:0] {
    RegTrim   = 3'd0,
    RegSpan   = 3'd1,
    RegDead   = 3'd2,
    RegFull   = 3'd3,
    RegLeft   = 3'd4,
    RegRight  = 3'd5,
    RegSilent = 3'd6
  } sfth_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic prep;      // load offset/magnitude of selected channel
    logic mul;       // load product into divider
    logic div_step;  // one restoring divide step
    logic store;     // write signed quotient to held thrust
    logic finish;    // commit frame: arm, seen, clear silence
    logic ch;        // 0 left, 1 right
  } sfth_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_good;  // good frame ended on this accepted word
    logic out_valid;   // output register full
  } sfth_status_t;

endpackage

// ===== hw/rtl/servo_frame_to_thrust_with_failsafe.sv =====
// Servo frame to thrust converter with deadband and loss-of-signal failsafe.
// Input stream: one word per beat. tuser = 0 carries a frame word in tdata with
// tlast on the final word; tuser = 1 is a time tick (tdata, tlast ignored).
// Frames with a bad magic or fewer than 20 words are dropped. A good frame
// turns the two configured channels into signed thrusts held for later ticks.
// Output stream: one word per tick once a good frame has been seen, carrying
// both thrusts, the armed flag and the timed-out flag.
// A frame word is taken when idle and not stalled. The word that ends a good
// frame starts a busy run without input (per channel: offset, multiply, 16-step
// shift-subtract divide, store); the divider is the pacing unit. A tick gives
// its result in the output register one cycle after acceptance, and the next
// word may be taken in the same cycle the result is taken.
// Stall: the output register holds its word while m_axis_tready_i is low; in
// that time further words are refused (tready low).
// Reset: configuration returns to its defaults, held thrusts, flags and the
// silence counter clear, and the output register empties.
module servo_frame_to_thrust_with_failsafe (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] frame_word
  input  logic        s_axis_tlast_i,   // word_last
  input  logic        s_axis_tuser_i,   // req_type
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [16:0] thrust_left, [33:17] thrust_right, zero pad
  output logic [1:0]  m_axis_tuser_o    // [0] armed, [1] timed_out
);
  import sfth_pkg::*;

  sfth_cmd_t    cmd;
  sfth_status_t status;
  logic         in_fire;
  logic [16:0]  thrust_left, thrust_right;
  logic         armed, timed_out;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  sfth_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .m_axis_tready_i (m_axis_tready_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .s_axis_tready_o (s_axis_tready_o)
  );

  sfth_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_fire_i       (in_fire),
    .req_type_i      (s_axis_tuser_i),
    .frame_word_i    (s_axis_tdata_i),
    .word_last_i     (s_axis_tlast_i),
    .m_axis_tready_i (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .thrust_left_o   (thrust_left),
    .thrust_right_o  (thrust_right),
    .armed_o         (armed),
    .timed_out_o     (timed_out),
    .cmd_i           (cmd),
    .status_o        (status)
  );

  // Pack output word
  assign m_axis_tdata_o = {6'b0, thrust_right, thrust_left};
  assign m_axis_tuser_o = {timed_out, armed};

endmodule

// ===== hw/rtl/sfth_ctrl.sv =====
module sfth_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  m_axis_tready_i,
  input  sfth_pkg::sfth_status_t status_i,
  output sfth_pkg::sfth_cmd_t   cmd_o,
  output logic                  s_axis_tready_o
);
  import sfth_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StMul,
    StDiv,
    StStore
  } state_e;

  state_e          state_d, state_q;
  logic            ch_d, ch_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            div_last;

  assign div_last = (cnt_q == CntW'(DivSteps - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (status_i.frame_good) begin
          state_d = StPrep;
          ch_d    = 1'b0;
        end
      end
      StPrep: state_d = StMul;
      StMul: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (div_last) state_d = StStore;
      end
      StStore: begin
        if (ch_q) begin
          state_d = StIdle;
        end else begin
          state_d = StPrep;
          ch_d    = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.ch       = ch_q;
    cmd_o.prep     = (state_q == StPrep);
    cmd_o.mul      = (state_q == StMul);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.store    = (state_q == StStore);
    cmd_o.finish   = (state_q == StStore) && ch_q;
  end

  // Take words only when idle and the output slot can take a tick result
  assign s_axis_tready_o = (state_q == StIdle) && (!status_i.out_valid || m_axis_tready_i);

  `include "servo_frame_to_thrust_with_failsafe_assert.svh"

  `SFTH_ASSERT_NOW(a_good_only_idle, status_i.frame_good, state_q == StIdle, "frame end while busy")
  `SFTH_ASSERT_NEXT(a_div_runs, (state_q == StDiv) && !div_last, state_q == StDiv, "divide cut short")
  `SFTH_ASSERT_NEXT(a_mul_to_div, state_q == StMul, (state_q == StDiv) && (cnt_q == '0), "divide start")

endmodule

// ===== hw/rtl/sfth_dp.sv =====
module sfth_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  // accepted input word
  input  logic                   in_fire_i,
  input  logic                   req_type_i,
  input  logic [15:0]            frame_word_i,
  input  logic                   word_last_i,
  // output register
  input  logic                   m_axis_tready_i,
  output logic                   out_valid_o,
  output logic [16:0]            thrust_left_o,
  output logic [16:0]            thrust_right_o,
  output logic                   armed_o,
  output logic                   timed_out_o,
  // control
  input  sfth_pkg::sfth_cmd_t    cmd_i,
  output sfth_pkg::sfth_status_t status_o
);
  import sfth_pkg::*;

  // Configuration registers
  logic [11:0] trim_q;
  logic [10:0] span_q, dead_q;
  logic [15:0] full_q, limit_q;
  logic [4:0]  left_ch_q, right_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q     <= TrimRst;
      span_q     <= SpanRst;
      dead_q     <= DeadRst;
      full_q     <= FullRst;
      left_ch_q  <= LeftRst;
      right_ch_q <= RightRst;
      limit_q    <= SilentRst;
    end else if (cfg_we_i) begin
      unique case (sfth_reg_e'(cfg_idx_i))
        RegTrim:   trim_q     <= cfg_data_i[11:0];
        RegSpan:   span_q     <= cfg_data_i[10:0];
        RegDead:   dead_q     <= cfg_data_i[10:0];
        RegFull:   full_q     <= cfg_data_i;
        RegLeft:   left_ch_q  <= cfg_data_i[4:0];
        RegRight:  right_ch_q <= cfg_data_i[4:0];
        RegSilent: limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame capture
  logic        word_fire, tick_fire;
  logic [5:0]  pos_q, pos_inc;
  logic        magic_q, magic_new;
  logic [15:0] lpulse_q, rpulse_q, lpulse_new, rpulse_new;
  logic        lcap_q, rcap_q, lcap_new, rcap_new;
  logic        hit_l, hit_r, good;
  logic [15:0] calc_pulse_q [2];
  logic        calc_cap_q [2];

  assign word_fire = in_fire_i && !req_type_i;
  assign tick_fire = in_fire_i && req_type_i;

  assign magic_new  = (pos_q == '0) ? (frame_word_i == MagicShort || frame_word_i == MagicLong)
                                    : magic_q;
  assign hit_l      = (32'(left_ch_q) < MaxChannels) && (pos_q == HeaderWords + 6'(left_ch_q));
  assign hit_r      = (32'(right_ch_q) < MaxChannels) && (pos_q == HeaderWords + 6'(right_ch_q));
  assign lpulse_new = hit_l ? frame_word_i : lpulse_q;
  assign rpulse_new = hit_r ? frame_word_i : rpulse_q;
  assign lcap_new   = hit_l || lcap_q;
  assign rcap_new   = hit_r || rcap_q;
  assign pos_inc    = (pos_q == PosMax) ? pos_q : pos_q + 6'd1;
  assign good       = (pos_inc >= MinFrameWords) && magic_new;

  assign status_o.frame_good = word_fire && word_last_i && good;
  assign status_o.out_valid  = out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= 1'b0;
      lcap_q  <= 1'b0;
      rcap_q  <= 1'b0;
    end else if (word_fire) begin
      if (word_last_i) begin
        pos_q   <= '0;
        magic_q <= 1'b0;
        lcap_q  <= 1'b0;
        rcap_q  <= 1'b0;
      end else begin
        pos_q   <= pos_inc;
        magic_q <= magic_new;
        lcap_q  <= lcap_new;
        rcap_q  <= rcap_new;
      end
    end
  end

  // Pulse payload and the copy handed to the thrust calculation
  always_ff @(posedge clk_i) begin
    if (word_fire) begin
      lpulse_q <= lpulse_new;
      rpulse_q <= rpulse_new;
      if (status_o.frame_good) begin
        calc_pulse_q[0] <= lpulse_new;
        calc_pulse_q[1] <= rpulse_new;
        calc_cap_q[0]   <= lcap_new;
        calc_cap_q[1]   <= rcap_new;
      end
    end
  end

  // Offset, deadband and clamp for the selected channel
  logic [15:0]        pulse;
  logic               in_range;
  logic signed [12:0] off;
  logic [11:0]        off_mag;
  logic [10:0]        mag_q;
  logic               neg_q, zero_q;

  assign pulse    = calc_pulse_q[cmd_i.ch];
  assign in_range = (pulse >= PulseMin) && (pulse <= PulseMax);
  assign off      = $signed({1'b0, pulse[11:0]}) - $signed({1'b0, trim_q});
  assign off_mag  = off[12] ? 12'(-off) : off[11:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q  <= off[12];
      zero_q <= !calc_cap_q[cmd_i.ch] || !in_range || (off_mag < {1'b0, dead_q})
                || (span_q == '0);
      mag_q  <= (off_mag > {1'b0, span_q}) ? span_q : off_mag[10:0];
    end
  end

  // Multiply into the divider, then one restoring step a cycle
  logic [10:0] rem_q;
  logic [15:0] quo_q;
  logic [12:0] trial;

  assign trial = {1'b0, rem_q, quo_q[15]} - {2'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      {rem_q, quo_q} <= 27'(full_q) * 27'(mag_q);
    end else if (cmd_i.div_step) begin
      if (!trial[12]) begin
        rem_q <= trial[10:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[9:0], quo_q[15]};
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end

  // Held thrusts, silence counter, flags
  logic [16:0] result;
  logic [16:0] held_q [2];
  logic        seen_q, armed_q;
  logic [15:0] silent_q, silent_inc;
  logic        expire;

  assign result     = zero_q ? '0 : (neg_q ? 17'(-{1'b0, quo_q}) : {1'b0, quo_q});
  assign silent_inc = (silent_q == '1) ? silent_q : silent_q + 16'd1;
  assign expire     = silent_inc > limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= '0;
      held_q[1] <= '0;
      seen_q    <= 1'b0;
      armed_q   <= 1'b0;
      silent_q  <= '0;
    end else begin
      if (cmd_i.store) held_q[cmd_i.ch] <= result;
      if (cmd_i.finish) begin
        seen_q   <= 1'b1;
        silent_q <= '0;
        if (held_q[0] != '0 || result != '0) armed_q <= 1'b1;
      end
      if (tick_fire && seen_q) begin
        silent_q <= silent_inc;
        if (expire) begin
          held_q[0] <= '0;
          held_q[1] <= '0;
        end
      end
    end
  end

  // Output register
  logic emit;

  assign emit = tick_fire && seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      thrust_left_o  <= expire ? '0 : held_q[0];
      thrust_right_o <= expire ? '0 : held_q[1];
      armed_o        <= armed_q;
      timed_out_o    <= expire;
    end
  end

  `include "servo_frame_to_thrust_with_failsafe_assert.svh"

  `SFTH_ASSERT_NEXT(a_armed_sticky, armed_q, armed_q, "armed flag dropped")
  `SFTH_ASSERT_NOW(a_timeout_zero, out_valid_o && timed_out_o,
                   thrust_left_o == '0 && thrust_right_o == '0, "thrust live after timeout")

endmodule

// ===== dv/servo_frame_to_thrust_with_failsafe_tb.sv =====
module servo_frame_to_thrust_with_failsafe_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfth_pkg::*;

  localparam logic KindFrame = 1'b0;
  localparam logic KindTick  = 1'b1;

  localparam int ClkPeriod    = 12;
  localparam int SettleCycles = 60;    // covers the divide after a good frame
  localparam int LongHold     = 400;   // receiver back-pressure stretch
  localparam int QuietLimit   = 4000;  // cycles without any handshake
  localparam int NumPhases    = 8;
  localparam int PhaseWords   = 130;
  localparam int MaxPrinted   = 40;

  // One input word: tuser = kind, tdata = frame word, tlast = end of frame
  typedef struct {
    logic        kind;
    logic [15:0] data;
    logic        last;
  } servo_word_t;

  typedef struct {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic               armed;
    logic               timed_out;
  } thrust_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [2:0]  cfg_idx  = '0;
  logic [15:0] cfg_data = '0;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [15:0] s_data   = '0;
  logic        s_last   = 1'b0;
  logic        s_user   = 1'b0;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [39:0] m_data;
  logic [1:0]  m_user;

  servo_frame_to_thrust_with_failsafe i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [15:0] frame_word
    .s_axis_tlast_i  (s_last),   // word_last
    .s_axis_tuser_i  (s_user),   // req_type
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [16:0] thrust_left, [33:17] thrust_right
    .m_axis_tuser_o  (m_user)    // [0] armed, [1] timed_out
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Shadow copy of the configuration registers
  logic [11:0] cfg_trim    = TrimRst;
  logic [10:0] cfg_span    = SpanRst;
  logic [10:0] cfg_dead    = DeadRst;
  logic [15:0] cfg_full    = FullRst;
  logic [4:0]  cfg_left    = LeftRst;
  logic [4:0]  cfg_right   = RightRst;
  logic [15:0] cfg_silence = SilentRst;

  // Decoder state
  logic [5:0]         word_pos    = '0;
  logic               magic_ok    = 1'b0;
  logic [15:0]        left_pulse  = '0;
  logic [15:0]        right_pulse = '0;
  logic               left_got    = 1'b0;
  logic               right_got   = 1'b0;
  logic signed [16:0] left_held   = '0;
  logic signed [16:0] right_held  = '0;
  logic               frame_seen  = 1'b0;
  logic               armed_state = 1'b0;
  logic [15:0]        silent_cnt  = '0;

  servo_word_t pending_words[$];
  thrust_t     expected_thrusts[$];
  servo_word_t cur_word;

  int n_queued = 0;
  int n_taken = 0;
  int n_errors = 0;
  int n_results = 0;
  int n_failsafe = 0;
  int n_good_frames = 0;
  int n_dropped_frames = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int rx_hold_left = 0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int quiet_cycles = 0;

  // Pulse width to signed thrust in mN, truncated toward zero
  function automatic logic signed [16:0] thrust_from_pulse(logic [15:0] pulse);
    int off;
    int mag;
    int span;
    longint q;
    if (pulse < PulseMin || pulse > PulseMax) return '0;
    off = int'(pulse) - int'(cfg_trim);
    mag = (off < 0) ? -off : off;
    if (mag < int'(cfg_dead)) return '0;
    span = int'(cfg_span);
    if (span == 0) return '0;
    if (off > span) off = span;
    if (off < -span) off = -span;
    mag = (off < 0) ? -off : off;
    q = (longint'(cfg_full) * longint'(mag)) / longint'(span);
    return (off < 0) ? 17'(-q) : 17'(q);
  endfunction

  // Apply one accepted word to the decoder state; ticks after a good frame queue a result
  task automatic advance_decoder(servo_word_t w);
    thrust_t res;
    if (w.kind == KindFrame) begin
      if (word_pos == '0) magic_ok = (w.data == MagicShort || w.data == MagicLong);
      if (int'(cfg_left) < MaxChannels &&
          int'(word_pos) == int'(HeaderWords) + int'(cfg_left)) begin
        left_pulse = w.data;
        left_got   = 1'b1;
      end
      if (int'(cfg_right) < MaxChannels &&
          int'(word_pos) == int'(HeaderWords) + int'(cfg_right)) begin
        right_pulse = w.data;
        right_got   = 1'b1;
      end
      if (word_pos < PosMax) word_pos++;
      if (w.last) begin
        if (word_pos >= MinFrameWords && magic_ok) begin
          left_held  = left_got ? thrust_from_pulse(left_pulse) : '0;
          right_held = right_got ? thrust_from_pulse(right_pulse) : '0;
          frame_seen = 1'b1;
          silent_cnt = '0;
          if (left_held != 0 || right_held != 0) armed_state = 1'b1;
          n_good_frames++;
        end else begin
          n_dropped_frames++;
        end
        word_pos    = '0;
        magic_ok    = 1'b0;
        left_pulse  = '0;
        right_pulse = '0;
        left_got    = 1'b0;
        right_got   = 1'b0;
      end
    end else if (frame_seen) begin
      res.timed_out = 1'b0;
      if (silent_cnt != 16'hFFFF) silent_cnt++;
      if (silent_cnt > cfg_silence) begin
        left_held     = '0;
        right_held    = '0;
        res.timed_out = 1'b1;
      end
      res.left  = left_held;
      res.right = right_held;
      res.armed = armed_state;
      expected_thrusts.push_back(res);
    end
  endtask

  // Zero unless the idle draw hits; then mostly a short gap, rarely a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    n_errors++;
    if (n_errors <= MaxPrinted)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic nxt_valid;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      nxt_valid = s_valid;
      if (s_valid && s_ready) begin
        advance_decoder(cur_word);
        n_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          s_data <= cur_word.data;
          s_last <= cur_word.last;
          s_user <= cur_word.kind;
          nxt_valid = 1'b1;
          tx_gap = pick_gap(tx_idle_pct);
        end
      end
      s_valid <= nxt_valid;
    end
  end

  // Output monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : watch_thrusts
    thrust_t want;
    logic rdy;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_stall = 0;
      rx_hold_left = 0;
    end else begin
      if (m_valid && m_ready) begin
        n_results++;
        if (m_user[1]) n_failsafe++;
        if (expected_thrusts.size() == 0) begin
          report_mismatch("unexpected word", int'($signed(m_data[16:0])), 0);
        end else begin
          want = expected_thrusts.pop_front();
          if (m_data[16:0] !== want.left)
            report_mismatch("thrust_left", int'($signed(m_data[16:0])), int'(want.left));
          if (m_data[33:17] !== want.right)
            report_mismatch("thrust_right", int'($signed(m_data[33:17])), int'(want.right));
          if (m_user[0] !== want.armed)
            report_mismatch("armed", int'(m_user[0]), int'(want.armed));
          if (m_user[1] !== want.timed_out)
            report_mismatch("timed_out", int'(m_user[1]), int'(want.timed_out));
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rdy = 1'b0;
      end else if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = LongHold;
        rdy = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rdy = 1'b0;
      end else begin
        rx_stall = pick_gap(rx_idle_pct);
        rdy = (rx_stall == 0);
      end
      m_ready <= rdy;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_thrusts.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_word(logic kind, logic [15:0] data, logic last);
    servo_word_t w;
    w.kind = kind;
    w.data = data;
    w.last = last;
    pending_words.push_back(w);
    n_queued++;
  endtask

  // Tick words carry random don't-care data and last
  task automatic queue_tick();
    queue_word(KindTick, 16'($urandom), 1'($urandom));
  endtask

  // Pulse widths clustered on the decision points of the current setting
  function automatic logic [15:0] pick_pulse();
    int sel;
    int sgn;
    sel = $urandom_range(9);
    sgn = $urandom_range(1) ? 1 : -1;
    case (sel)
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return PulseMin - 16'd1;
          1: return PulseMin;
          2: return PulseMax;
          default: return PulseMax + 16'd1;
        endcase
      end
      2, 3: return 16'(int'(cfg_trim) + sgn * (int'(cfg_dead) + $urandom_range(2) - 1));
      4, 5: return 16'(int'(cfg_trim) + sgn * (int'(cfg_span) + $urandom_range(4) - 2));
      default: return 16'($urandom_range(2200, 800));
    endcase
  endfunction

  // Header, then pulses; a tick may slip in between frame words
  task automatic queue_frame(logic [15:0] magic, int len);
    logic [15:0] data;
    for (int i = 0; i < len; i++) begin
      if (i == 0) data = magic;
      else if (i < int'(HeaderWords)) data = 16'($urandom);
      else data = pick_pulse();
      queue_word(KindFrame, data, i == len - 1);
      if (i > 0 && $urandom_range(19) == 0) queue_tick();
    end
  endtask

  function automatic logic [15:0] good_magic();
    return $urandom_range(1) ? MagicShort : MagicLong;
  endfunction

  // Mostly well-formed frames with ticks after them; some short, bad or noise
  task automatic queue_random_burst();
    int sel;
    int len;
    int n;
    logic [15:0] bad;
    sel = $urandom_range(99);
    if (sel < 65) begin
      n = $urandom_range(9);
      len = (n < 7) ? $urandom_range(40, 20) : (n < 9) ? $urandom_range(70, 41) : 20;
      queue_frame(good_magic(), len);
    end else if (sel < 75) begin
      queue_frame(good_magic(), $urandom_range(19, 1));
    end else if (sel < 85) begin
      do bad = 16'($urandom); while (bad == MagicShort || bad == MagicLong);
      queue_frame(bad, $urandom_range(40, 1));
    end else begin
      repeat ($urandom_range(8, 1))
        queue_word(1'($urandom), 16'($urandom), 1'($urandom));
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 0);
    repeat (n) queue_tick();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (n_queued != n_taken || expected_thrusts.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(sfth_reg_e idx, int val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= 16'(val);
  endtask

  // Write every register, then mirror the new setting
  task automatic load_setting(int trim, int span, int dead, int full,
                              int lch, int rch, int silence);
    write_reg(RegTrim, trim);
    write_reg(RegSpan, span);
    write_reg(RegDead, dead);
    write_reg(RegFull, full);
    write_reg(RegLeft, lch);
    write_reg(RegRight, rch);
    write_reg(RegSilent, silence);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_trim    = 12'(trim);
    cfg_span    = 11'(span);
    cfg_dead    = 11'(dead);
    cfg_full    = 16'(full);
    cfg_left    = 5'(lch);
    cfg_right   = 5'(rch);
    cfg_silence = 16'(silence);
    @(negedge clk_i);
  endtask

  initial begin
    int budget;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset setting: ticks before any frame, a short frame,
    // then a good frame with both pulse extremes on the mapped channels
    queue_tick();
    queue_frame(MagicLong, 5);
    queue_tick();
    for (int i = 0; i < 20; i++)
      queue_word(KindFrame, (i == 0) ? MagicShort : (i == 4) ? PulseMax :
                 (i == 6) ? PulseMin : 16'd1500, i == 19);
    queue_tick();
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_setting(TrimRst, SpanRst, DeadRst, FullRst, LeftRst, RightRst, 1);
        1: load_setting(800, 1400, 0, 65535, 31, 0, 2);
        2: load_setting(2200, 1, 1400, 0, 15, 16, 65535);
        // zero span and zero silence limit; right channel only in long frames
        3: load_setting(1500, 0, 5, 1000, 3, 31, 0);
        default: load_setting($urandom_range(2200, 800), $urandom_range(1400, 1),
                              ($urandom_range(9) == 0) ? $urandom_range(1400, 0)
                                                       : $urandom_range(60, 0),
                              $urandom_range(65535, 0), $urandom_range(31, 0),
                              $urandom_range(31, 0), $urandom_range(8, 1));
      endcase
      tx_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 60;
      rx_idle_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 40 : 20;

      // Long receiver stall with the sender still pushing ticks
      if (ph == 0) begin
        rx_hold_req++;
        repeat (30) queue_tick();
        queue_frame(MagicShort, 24);
        repeat (10) queue_tick();
        wait_drained();
      end

      budget = n_queued + PhaseWords;
      while (n_queued < budget) begin
        queue_random_burst();
        // sender pause mid-phase until all results are back
        if (n_queued >= budget - PhaseWords / 2 && n_queued < budget - PhaseWords / 2 + 8)
          wait_drained();
      end
      wait_drained();
    end

    if (expected_thrusts.size() != 0)
      report_mismatch("results missing", 0, expected_thrusts.size());
    $display("Covered %0d words in %0d settings: %0d good frames, %0d dropped frames,",
             n_taken, NumPhases + 1, n_good_frames, n_dropped_frames);
    $display("  %0d thrust words checked, %0d of them failsafe timeouts, %0d mismatches",
             n_results, n_failsafe, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
